// ===== hdl/rrts_pkg.sv =====
// shared types, constants and helpers of the round-robin task scheduler
package rrts_pkg;

   localparam int NUM_SLOTS    = 16;
   localparam int SLOT_BITS    = $clog2(NUM_SLOTS);
   localparam int SUM_BITS     = SLOT_BITS + 1;
   localparam int ID_BITS      = 16;
   localparam int QUANTUM_BITS = 8;
   localparam int FUNC_BITS    = 3;
   localparam int VEC_BITS     = 5;
   localparam int RES_BITS     = 3;

   localparam logic [QUANTUM_BITS-1:0] QUANTUM_RESET     = QUANTUM_BITS'(5);
   localparam logic [VEC_BITS-1:0]     VEC_DOUBLE_FAULT  = VEC_BITS'(8);
   localparam logic [VEC_BITS-1:0]     VEC_MACHINE_CHECK = VEC_BITS'(18);

   typedef logic [SLOT_BITS-1:0]    slot_addr_type;
   typedef logic [ID_BITS-1:0]      pid_type;
   typedef logic [QUANTUM_BITS-1:0] quantum_type;
   typedef logic [VEC_BITS-1:0]     vec_type;

   localparam slot_addr_type LAST_STEP = SLOT_BITS'(NUM_SLOTS - 1);

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_TICK, FUNC_ADD, FUNC_EXIT, FUNC_YIELD,
      FUNC_SLEEP, FUNC_WAKE, FUNC_WAIT, FUNC_FAULT
   } func_type;

   typedef enum logic [RES_BITS-1:0] {
      RES_OK, RES_FULL, RES_UNKNOWN, RES_HALTED, RES_NO_READY
   } res_code_type;

   typedef enum logic [1:0] {
      TASK_READY, TASK_SLEEPING, TASK_WAITING
   } task_status_type;

   typedef enum logic [1:0] {
      SCAN_MATCH_ID, SCAN_FREE, SCAN_READY, SCAN_WAITER
   } scan_mode_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_LOOKUP, S_FREE, S_REMOVE, S_WAKE, S_PICK, S_DONE
   } seq_state_type;

   typedef struct packed {
      scan_mode_type   mode;
      slot_addr_type   addr;
      pid_type         key;
      slot_addr_type   wr_addr;
      logic            we_valid;
      logic            valid_val;
      logic            we_id;
      logic            we_status;
      logic            we_wait;
      pid_type         wr_id;
      task_status_type wr_status;
      pid_type         wr_wait;
   } tbl_req_type;

   typedef struct packed {
      logic                 hit;
      pid_type              rd_id;
      logic [NUM_SLOTS-1:0] valid_vec;
   } tbl_rsp_type;

   typedef struct packed {
      res_code_type status;
      pid_type      current_pid;
      logic         switched;
      pid_type      assigned_pid;
   } rsp_word_type;

   function automatic slot_addr_type wrap_add(slot_addr_type base, slot_addr_type step);
      logic [SUM_BITS-1:0] sum;
      sum = {1'b0, base} + {1'b0, step};
      if (sum >= SUM_BITS'(NUM_SLOTS)) begin
         sum = sum - SUM_BITS'(NUM_SLOTS);
      end
      return sum[SLOT_BITS-1:0];
   endfunction

   function automatic slot_addr_type next_slot(slot_addr_type slot);
      return wrap_add(slot, SLOT_BITS'(1));
   endfunction

endpackage

// ===== hdl/round_robin_task_scheduler.sv =====
// top level of the round-robin task scheduler with quantum register and result word
//
//  channel   ports                          handshake
//  req       req_func .. req_fault_user_mode  start high, busy low
//  rsp       rsp_status .. rsp_assigned_pid   rsp_strobe, one cycle, no stall
//  csr       csr_data (quantum_ticks)         csr_valid and csr_ready
//
// a halted command goes straight from dispatch to done; exit runs an id lookup, a waiter
// sweep and, if it removed the running task, a ready search (unless it removed the last task),
// each walking the slot table one slot per cycle through the shared slot compare
// the result word comes out in the same cycle as busy falls
// reset clears the slot valid bits at once, with no clearing pass
module round_robin_task_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [rrts_pkg::FUNC_BITS-1:0]      req_func,
   input  logic [rrts_pkg::ID_BITS-1:0]        req_target_pid,
   input  logic [rrts_pkg::VEC_BITS-1:0]       req_fault_vector,
   input  logic                                req_fault_user_mode,
   output logic                                rsp_strobe,
   output logic [rrts_pkg::RES_BITS-1:0]       rsp_status,
   output logic [rrts_pkg::ID_BITS-1:0]        rsp_current_pid,
   output logic                                rsp_switched,
   output logic [rrts_pkg::ID_BITS-1:0]        rsp_assigned_pid,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rrts_pkg::QUANTUM_BITS-1:0]   csr_data
);
   import rrts_pkg::*;

   quantum_type  quantum_ff;
   logic         accept;
   logic         done;
   logic         seq_busy;
   tbl_req_type  tbl_req;
   tbl_rsp_type  tbl_rsp;
   rsp_word_type rsp_word;

   logic         rsp_strobe_ff;
   rsp_word_type rsp_word_ff;

   assign csr_ready = 1'b1;
   assign accept    = start && !seq_busy;
   assign busy      = seq_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_valid && csr_ready) begin
         quantum_ff <= csr_data;
      end
   end

   rrts_slot_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

   rrts_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .req_func            (func_type'(req_func)),
      .req_target_pid      (req_target_pid),
      .req_fault_vector    (req_fault_vector),
      .req_fault_user_mode (req_fault_user_mode),
      .quantum             (quantum_ff),
      .tbl_rsp             (tbl_rsp),
      .tbl_req             (tbl_req),
      .busy                (seq_busy),
      .done                (done),
      .rsp_word            (rsp_word)
   );

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_word_ff <= rsp_word;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_word_ff.status;
   assign rsp_current_pid  = rsp_word_ff.current_pid;
   assign rsp_switched     = rsp_word_ff.switched;
   assign rsp_assigned_pid = rsp_word_ff.assigned_pid;

endmodule

// ===== hdl/rrts_slot_table.sv =====
// task slot table with one scan read port, one write port and the shared slot compare
module rrts_slot_table (
   input  logic                 clock,
   input  logic                 reset,
   input  rrts_pkg::tbl_req_type tbl_req,
   output rrts_pkg::tbl_rsp_type tbl_rsp
);
   import rrts_pkg::*;

   logic [NUM_SLOTS-1:0] valid_ff;
   pid_type              id_ff     [NUM_SLOTS];
   task_status_type      status_ff [NUM_SLOTS];
   pid_type              wait_ff   [NUM_SLOTS];

   logic            rd_valid;
   pid_type         rd_id;
   task_status_type rd_status;
   pid_type         rd_wait;
   logic            hit;

   assign rd_valid  = valid_ff[tbl_req.addr];
   assign rd_id     = id_ff[tbl_req.addr];
   assign rd_status = status_ff[tbl_req.addr];
   assign rd_wait   = wait_ff[tbl_req.addr];

   always_comb begin
      unique case (tbl_req.mode)
         SCAN_MATCH_ID: hit = rd_valid && (rd_id == tbl_req.key);
         SCAN_FREE:     hit = !rd_valid;
         SCAN_READY:    hit = rd_valid && (rd_status == TASK_READY);
         SCAN_WAITER:   hit = rd_valid && (rd_status == TASK_WAITING)
                              && (rd_wait == tbl_req.key);
      endcase
   end

   assign tbl_rsp.hit       = hit;
   assign tbl_rsp.rd_id     = rd_id;
   assign tbl_rsp.valid_vec = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (tbl_req.we_valid) begin
         valid_ff[tbl_req.wr_addr] <= tbl_req.valid_val;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.we_id) begin
         id_ff[tbl_req.wr_addr] <= tbl_req.wr_id;
      end
      if (tbl_req.we_status) begin
         status_ff[tbl_req.wr_addr] <= tbl_req.wr_status;
      end
      if (tbl_req.we_wait) begin
         wait_ff[tbl_req.wr_addr] <= tbl_req.wr_wait;
      end
   end

endmodule

// ===== hdl/rrts_seq.sv =====
// command sequencer: slot scans, task state and result word of the scheduler
module rrts_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  rrts_pkg::func_type    req_func,
   input  rrts_pkg::pid_type     req_target_pid,
   input  rrts_pkg::vec_type     req_fault_vector,
   input  logic                  req_fault_user_mode,
   input  rrts_pkg::quantum_type quantum,
   input  rrts_pkg::tbl_rsp_type tbl_rsp,
   output rrts_pkg::tbl_req_type tbl_req,
   output logic                  busy,
   output logic                  done,
   output rrts_pkg::rsp_word_type rsp_word
);
   import rrts_pkg::*;

   seq_state_type state_ff, state_in;
   func_type      func_ff, func_in;
   pid_type       target_ff, target_in;
   vec_type       vec_ff, vec_in;
   logic          user_ff, user_in;
   slot_addr_type slot_t_ff, slot_t_in;
   slot_addr_type base_ff, base_in;
   slot_addr_type step_ff, step_in;
   pid_type       key_ff, key_in;
   logic          force_ff, force_in;
   slot_addr_type cur_slot_ff, cur_slot_in;
   logic          cur_valid_ff, cur_valid_in;
   pid_type       cur_id_ff, cur_id_in;
   quantum_type   tick_ff, tick_in;
   pid_type       next_id_ff, next_id_in;
   logic          halted_ff, halted_in;
   res_code_type  res_status_ff, res_status_in;
   logic          res_sw_ff, res_sw_in;
   pid_type       res_assigned_ff, res_assigned_in;

   slot_addr_type        scan_addr;
   slot_addr_type        resched_first;
   logic                 last_step;
   logic                 halt_fault;
   logic                 tick_expire;
   quantum_type          tick_plus;
   pid_type              nid_plus;
   logic [NUM_SLOTS-1:0] others;
   logic                 others_empty;

   assign scan_addr     = wrap_add(base_ff, step_ff);
   assign resched_first = cur_valid_ff ? next_slot(cur_slot_ff) : '0;
   assign last_step     = (step_ff == LAST_STEP);
   assign halt_fault    = (vec_ff == VEC_DOUBLE_FAULT) || (vec_ff == VEC_MACHINE_CHECK)
                          || !user_ff;
   assign tick_plus     = tick_ff + QUANTUM_BITS'(1);
   assign tick_expire   = (tick_plus >= quantum);
   assign nid_plus      = next_id_ff + ID_BITS'(1);

   always_comb begin
      others            = tbl_rsp.valid_vec;
      others[slot_t_ff] = 1'b0;
   end
   assign others_empty = (others == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (halted_ff) begin
               state_in = S_DONE;
            end else begin
               unique case (func_ff)
                  FUNC_TICK:  state_in = (!cur_valid_ff || tick_expire) ? S_PICK : S_DONE;
                  FUNC_ADD:   state_in = S_FREE;
                  FUNC_EXIT,
                  FUNC_WAKE,
                  FUNC_WAIT:  state_in = S_LOOKUP;
                  FUNC_YIELD,
                  FUNC_SLEEP: state_in = S_PICK;
                  FUNC_FAULT: state_in = (!halt_fault && cur_valid_ff) ? S_REMOVE : S_DONE;
               endcase
            end
         end
         S_LOOKUP: begin
            priority if (tbl_rsp.hit && func_ff == FUNC_EXIT) begin
               state_in = S_REMOVE;
            end else if (tbl_rsp.hit && func_ff == FUNC_WAIT) begin
               state_in = S_PICK;
            end else if (tbl_rsp.hit || last_step) begin
               state_in = S_DONE;
            end
         end
         S_FREE: begin
            if (tbl_rsp.hit || last_step) state_in = S_DONE;
         end
         S_REMOVE: begin
            state_in = others_empty ? S_DONE : S_WAKE;
         end
         S_WAKE: begin
            if (last_step) state_in = force_ff ? S_PICK : S_DONE;
         end
         S_PICK: begin
            if (tbl_rsp.hit || last_step) state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and table access
   always_comb begin
      func_in         = func_ff;
      target_in       = target_ff;
      vec_in          = vec_ff;
      user_in         = user_ff;
      slot_t_in       = slot_t_ff;
      base_in         = base_ff;
      step_in         = step_ff;
      key_in          = key_ff;
      force_in        = force_ff;
      cur_slot_in     = cur_slot_ff;
      cur_valid_in    = cur_valid_ff;
      cur_id_in       = cur_id_ff;
      tick_in         = tick_ff;
      next_id_in      = next_id_ff;
      halted_in       = halted_ff;
      res_status_in   = res_status_ff;
      res_sw_in       = res_sw_ff;
      res_assigned_in = res_assigned_ff;

      tbl_req           = '0;
      tbl_req.addr      = scan_addr;
      tbl_req.key       = key_ff;
      tbl_req.wr_addr   = scan_addr;
      tbl_req.wr_status = TASK_READY;
      unique case (state_ff)
         S_LOOKUP: tbl_req.mode = SCAN_MATCH_ID;
         S_FREE:   tbl_req.mode = SCAN_FREE;
         S_WAKE:   tbl_req.mode = SCAN_WAITER;
         S_PICK:   tbl_req.mode = SCAN_READY;
         default:  tbl_req.mode = SCAN_MATCH_ID;
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in         = req_func;
               target_in       = req_target_pid;
               vec_in          = req_fault_vector;
               user_in         = req_fault_user_mode;
               res_status_in   = RES_OK;
               res_sw_in       = 1'b0;
               res_assigned_in = '0;
               force_in        = 1'b0;
            end
         end
         S_DISPATCH: begin
            base_in = '0;
            step_in = '0;
            key_in  = target_ff;
            if (halted_ff) begin
               res_status_in = RES_HALTED;
            end else begin
               unique case (func_ff)
                  FUNC_TICK: begin
                     if (!cur_valid_ff || tick_expire) begin
                        base_in = resched_first;
                        tick_in = '0;
                     end else begin
                        tick_in = tick_plus;
                     end
                  end
                  FUNC_ADD, FUNC_EXIT, FUNC_WAKE, FUNC_WAIT: begin
                  end
                  FUNC_YIELD: begin
                     base_in = resched_first;
                     tick_in = '0;
                  end
                  FUNC_SLEEP: begin
                     if (cur_valid_ff) begin
                        tbl_req.wr_addr   = cur_slot_ff;
                        tbl_req.we_status = 1'b1;
                        tbl_req.wr_status = TASK_SLEEPING;
                     end
                     base_in = resched_first;
                     tick_in = '0;
                  end
                  FUNC_FAULT: begin
                     if (halt_fault) begin
                        res_sw_in     = cur_valid_ff;
                        cur_valid_in  = 1'b0;
                        halted_in     = 1'b1;
                        res_status_in = RES_HALTED;
                     end else if (cur_valid_ff) begin
                        slot_t_in = cur_slot_ff;
                        key_in    = cur_id_ff;
                     end else begin
                        res_status_in = RES_UNKNOWN;
                     end
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            step_in = step_ff + SLOT_BITS'(1);
            if (tbl_rsp.hit) begin
               unique case (func_ff)
                  FUNC_EXIT: begin
                     slot_t_in = scan_addr;
                  end
                  FUNC_WAKE: begin
                     tbl_req.we_status = 1'b1;
                     tbl_req.wr_status = TASK_READY;
                     tbl_req.we_wait   = 1'b1;
                     tbl_req.wr_wait   = '0;
                  end
                  FUNC_WAIT: begin
                     if (cur_valid_ff) begin
                        tbl_req.wr_addr   = cur_slot_ff;
                        tbl_req.we_status = 1'b1;
                        tbl_req.wr_status = TASK_WAITING;
                        tbl_req.we_wait   = 1'b1;
                        tbl_req.wr_wait   = key_ff;
                     end
                     base_in = resched_first;
                     step_in = '0;
                     tick_in = '0;
                  end
                  default: begin
                  end
               endcase
            end else if (last_step) begin
               res_status_in = RES_UNKNOWN;
            end
         end
         S_FREE: begin
            step_in = step_ff + SLOT_BITS'(1);
            if (tbl_rsp.hit) begin
               tbl_req.we_valid  = 1'b1;
               tbl_req.valid_val = 1'b1;
               tbl_req.we_id     = 1'b1;
               tbl_req.wr_id     = next_id_ff;
               tbl_req.we_status = 1'b1;
               tbl_req.wr_status = TASK_READY;
               tbl_req.we_wait   = 1'b1;
               tbl_req.wr_wait   = '0;
               res_assigned_in   = next_id_ff;
               next_id_in        = (nid_plus == '0) ? ID_BITS'(1) : nid_plus;
            end else if (last_step) begin
               res_status_in = RES_FULL;
            end
         end
         S_REMOVE: begin
            if (others_empty) begin
               res_sw_in     = cur_valid_ff;
               cur_valid_in  = 1'b0;
               halted_in     = 1'b1;
               res_status_in = RES_HALTED;
            end else begin
               tbl_req.wr_addr   = slot_t_ff;
               tbl_req.we_valid  = 1'b1;
               tbl_req.valid_val = 1'b0;
               force_in          = cur_valid_ff && (cur_slot_ff == slot_t_ff);
               base_in           = '0;
               step_in           = '0;
            end
         end
         S_WAKE: begin
            step_in = step_ff + SLOT_BITS'(1);
            if (tbl_rsp.hit) begin
               tbl_req.we_status = 1'b1;
               tbl_req.wr_status = TASK_READY;
               tbl_req.we_wait   = 1'b1;
               tbl_req.wr_wait   = '0;
            end
            if (last_step && force_ff) begin
               cur_valid_in = 1'b0;
               base_in      = next_slot(slot_t_ff);
               step_in      = '0;
               tick_in      = '0;
            end
         end
         S_PICK: begin
            step_in = step_ff + SLOT_BITS'(1);
            if (tbl_rsp.hit) begin
               cur_slot_in   = scan_addr;
               cur_valid_in  = 1'b1;
               cur_id_in     = tbl_rsp.rd_id;
               res_sw_in     = force_ff || !(cur_valid_ff && (cur_slot_ff == scan_addr));
               res_status_in = RES_OK;
            end else if (last_step) begin
               cur_valid_in  = 1'b0;
               res_sw_in     = force_ff || cur_valid_ff;
               res_status_in = RES_NO_READY;
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
         tick_ff      <= '0;
         next_id_ff   <= ID_BITS'(1);
         halted_ff    <= 1'b0;
         force_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_slot_ff  <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
         tick_ff      <= tick_in;
         next_id_ff   <= next_id_in;
         halted_ff    <= halted_in;
         force_ff     <= force_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      target_ff       <= target_in;
      vec_ff          <= vec_in;
      user_ff         <= user_in;
      slot_t_ff       <= slot_t_in;
      base_ff         <= base_in;
      step_ff         <= step_in;
      key_ff          <= key_in;
      cur_id_ff       <= cur_id_in;
      res_status_ff   <= res_status_in;
      res_sw_ff       <= res_sw_in;
      res_assigned_ff <= res_assigned_in;
   end

   assign busy                  = (state_ff != S_IDLE);
   assign done                  = (state_ff == S_DONE);
   assign rsp_word.status       = res_status_ff;
   assign rsp_word.current_pid  = cur_valid_ff ? cur_id_ff : '0;
   assign rsp_word.switched     = res_sw_ff;
   assign rsp_word.assigned_pid = res_assigned_ff;

   a_halt_no_task: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !cur_valid_ff)
      else $error("running task while halted");

   a_next_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != '0)
      else $error("next id is zero");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_IDLE))
      else $error("result word not single cycle");

   a_cur_slot_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && cur_valid_ff) |-> tbl_rsp.valid_vec[cur_slot_ff])
      else $error("running slot not valid");

endmodule

// ===== test/round_robin_task_scheduler_test.sv =====
// self-checking test of the round-robin task scheduler: directed table, random commands, quanta
module round_robin_task_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rrts_pkg::*;

   typedef struct {
      func_type     f;
      pid_type      target;
      vec_type      vec;
      logic         user;
      logic         typed;
      rsp_word_type word;
   } cmd_row_type;

   localparam int DIRECTED_COUNT = 24;
   localparam int PHASE_ITEMS    = 125;
   localparam rsp_word_type NO_WORD = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   func_type    req_func = FUNC_TICK;
   pid_type     req_target_pid = '0;
   vec_type     req_fault_vector = '0;
   logic        req_fault_user_mode = 1'b0;
   logic        rsp_strobe;
   logic [RES_BITS-1:0] rsp_status;
   pid_type     rsp_current_pid;
   logic        rsp_switched;
   pid_type     rsp_assigned_pid;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   quantum_type csr_data = '0;

   // scheduler state as predicted
   logic            task_live    [NUM_SLOTS];
   pid_type         task_pid     [NUM_SLOTS];
   task_status_type task_state   [NUM_SLOTS];
   pid_type         task_wait_on [NUM_SLOTS];
   slot_addr_type   run_slot;
   logic            running;
   quantum_type     tick_total;
   pid_type         id_counter;
   logic            sched_halted;
   quantum_type     quantum_reg;

   rsp_word_type due_words [$];
   int           sender_idle_pct = 0;
   int           items_sent = 0;
   int           words_checked = 0;
   int           mismatch_count = 0;

   cmd_row_type directed_rows [DIRECTED_COUNT] = '{
      '{FUNC_TICK,  16'h0000, 5'd0,  1'b0, 1'b1, '{RES_NO_READY, 16'h0, 1'b0, 16'h0}},
      '{FUNC_YIELD, 16'hFFFF, 5'd31, 1'b1, 1'b1, '{RES_NO_READY, 16'h0, 1'b0, 16'h0}},
      '{FUNC_SLEEP, 16'h0000, 5'd0,  1'b0, 1'b1, '{RES_NO_READY, 16'h0, 1'b0, 16'h0}},
      '{FUNC_WAIT,  16'hFFFF, 5'd0,  1'b0, 1'b1, '{RES_UNKNOWN,  16'h0, 1'b0, 16'h0}},
      '{FUNC_FAULT, 16'h0000, 5'd31, 1'b1, 1'b1, '{RES_UNKNOWN,  16'h0, 1'b0, 16'h0}},
      '{FUNC_EXIT,  16'h0000, 5'd0,  1'b0, 1'b1, '{RES_UNKNOWN,  16'h0, 1'b0, 16'h0}},
      '{FUNC_WAKE,  16'h0001, 5'd0,  1'b0, 1'b1, '{RES_UNKNOWN,  16'h0, 1'b0, 16'h0}},
      '{FUNC_ADD,   16'h0000, 5'd0,  1'b0, 1'b1, '{RES_OK,       16'h0, 1'b0, 16'h1}},
      '{FUNC_ADD,   16'hFFFF, 5'd0,  1'b0, 1'b1, '{RES_OK,       16'h0, 1'b0, 16'h2}},
      '{FUNC_ADD,   16'h0000, 5'd0,  1'b0, 1'b1, '{RES_OK,       16'h0, 1'b0, 16'h3}},
      '{FUNC_TICK,  16'h0000, 5'd0,  1'b0, 1'b1, '{RES_OK,       16'h1, 1'b1, 16'h0}},
      '{FUNC_TICK,  16'h0000, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_TICK,  16'h0000, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_TICK,  16'h0000, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_TICK,  16'h0000, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_TICK,  16'h0000, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_WAIT,  16'h0003, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_SLEEP, 16'h0000, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_EXIT,  16'h0003, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_FAULT, 16'h0000, 5'd0,  1'b1, 1'b0, NO_WORD},
      '{FUNC_WAKE,  16'h0002, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_ADD,   16'h0000, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_EXIT,  16'h0002, 5'd0,  1'b0, 1'b0, NO_WORD},
      '{FUNC_YIELD, 16'h0000, 5'd0,  1'b0, 1'b0, NO_WORD}
   };

   round_robin_task_scheduler DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_target_pid      (req_target_pid),
      .req_fault_vector    (req_fault_vector),
      .req_fault_user_mode (req_fault_user_mode),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_current_pid     (rsp_current_pid),
      .rsp_switched        (rsp_switched),
      .rsp_assigned_pid    (rsp_assigned_pid),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int find_task(input pid_type id);
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (task_live[s] && task_pid[s] == id) begin
            return s;
         end
      end
      return -1;
   endfunction

   function automatic int count_live();
      int n;
      n = 0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (task_live[s]) begin
            n++;
         end
      end
      return n;
   endfunction

   function automatic pid_type any_live_pid();
      int first;
      int s;
      first = $urandom_range(NUM_SLOTS - 1);
      for (int k = 0; k < NUM_SLOTS; k++) begin
         s = (first + k) % NUM_SLOTS;
         if (task_live[s]) begin
            return task_pid[s];
         end
      end
      return pid_type'($urandom_range(65535));
   endfunction

   function automatic res_code_type pick_ready(input int first, output logic sw);
      logic          was_running;
      slot_addr_type prev;
      int            s;
      was_running = running;
      prev = run_slot;
      tick_total = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         s = (first + k) % NUM_SLOTS;
         if (task_live[s] && task_state[s] == TASK_READY) begin
            run_slot = slot_addr_type'(s);
            running = 1'b1;
            sw = !(was_running && prev == slot_addr_type'(s));
            return RES_OK;
         end
      end
      running = 1'b0;
      sw = was_running;
      return RES_NO_READY;
   endfunction

   function automatic res_code_type reschedule(output logic sw);
      if (running) begin
         return pick_ready((int'(run_slot) + 1) % NUM_SLOTS, sw);
      end
      return pick_ready(0, sw);
   endfunction

   function automatic res_code_type halt_now(output logic sw);
      sw = running;
      running = 1'b0;
      sched_halted = 1'b1;
      return RES_HALTED;
   endfunction

   function automatic res_code_type remove_task(input int slot, output logic sw);
      logic         was_current;
      pid_type      id;
      res_code_type r;
      was_current = running && int'(run_slot) == slot;
      id = task_pid[slot];
      if (count_live() <= 1) begin
         return halt_now(sw);
      end
      task_live[slot] = 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (task_live[s] && task_state[s] == TASK_WAITING && task_wait_on[s] == id) begin
            task_state[s] = TASK_READY;
            task_wait_on[s] = '0;
         end
      end
      sw = 1'b0;
      if (was_current) begin
         running = 1'b0;
         r = pick_ready((slot + 1) % NUM_SLOTS, sw);
         sw = 1'b1;
         return r;
      end
      return RES_OK;
   endfunction

   function automatic rsp_word_type run_scheduler(input func_type f, input pid_type target,
                                                  input vec_type vec, input logic user);
      rsp_word_type word;
      res_code_type status;
      logic         sw;
      pid_type      assigned;
      int           t;
      logic         placed;
      word = NO_WORD;
      status = RES_OK;
      sw = 1'b0;
      assigned = '0;
      if (sched_halted) begin
         word.status = RES_HALTED;
         return word;
      end
      case (f)
         FUNC_TICK: begin
            if (!running) begin
               status = reschedule(sw);
            end else begin
               tick_total = tick_total + 1'b1;
               if (tick_total >= quantum_reg) begin
                  status = reschedule(sw);
               end
            end
         end
         FUNC_ADD: begin
            status = RES_FULL;
            placed = 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (!placed && !task_live[s]) begin
                  placed = 1'b1;
                  task_live[s] = 1'b1;
                  task_pid[s] = id_counter;
                  task_state[s] = TASK_READY;
                  task_wait_on[s] = '0;
                  assigned = id_counter;
                  id_counter = id_counter + 1'b1;
                  if (id_counter == '0) begin
                     id_counter = pid_type'(1);
                  end
                  status = RES_OK;
               end
            end
         end
         FUNC_EXIT: begin
            t = find_task(target);
            status = (t < 0) ? RES_UNKNOWN : remove_task(t, sw);
         end
         FUNC_YIELD: begin
            status = reschedule(sw);
         end
         FUNC_SLEEP: begin
            if (running) begin
               task_state[run_slot] = TASK_SLEEPING;
            end
            status = reschedule(sw);
         end
         FUNC_WAKE: begin
            t = find_task(target);
            if (t < 0) begin
               status = RES_UNKNOWN;
            end else begin
               task_state[t] = TASK_READY;
               task_wait_on[t] = '0;
            end
         end
         FUNC_WAIT: begin
            t = find_task(target);
            if (t < 0) begin
               status = RES_UNKNOWN;
            end else begin
               if (running) begin
                  task_state[run_slot] = TASK_WAITING;
                  task_wait_on[run_slot] = task_pid[t];
               end
               status = reschedule(sw);
            end
         end
         default: begin
            if (vec == VEC_DOUBLE_FAULT || vec == VEC_MACHINE_CHECK || !user) begin
               status = halt_now(sw);
            end else if (running) begin
               status = remove_task(int'(run_slot), sw);
            end else begin
               status = RES_UNKNOWN;
            end
         end
      endcase
      word.status = status;
      word.current_pid = running ? task_pid[run_slot] : '0;
      word.switched = sw;
      word.assigned_pid = assigned;
      return word;
   endfunction

   task automatic issue(input func_type f, input pid_type target, input vec_type vec,
                        input logic user, input logic use_typed, input rsp_word_type typed);
      rsp_word_type word;
      @(posedge clock);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      start <= 1'b1;
      req_func <= f;
      req_target_pid <= target;
      req_fault_vector <= vec;
      req_fault_user_mode <= user;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      word = run_scheduler(f, target, vec, user);
      due_words.push_back(use_typed ? typed : word);
      items_sent++;
   endtask

   task automatic write_quantum(input quantum_type q);
      while (due_words.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= q;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      quantum_reg = q;
   endtask

   // mostly well-formed commands on live ids, never one that would halt
   task automatic random_command();
      func_type f;
      pid_type  target;
      vec_type  vec;
      logic     user;
      int       r;
      r = $urandom_range(99);
      if (r < 22) f = FUNC_TICK;
      else if (r < 42) f = FUNC_ADD;
      else if (r < 49) f = FUNC_EXIT;
      else if (r < 60) f = FUNC_YIELD;
      else if (r < 67) f = FUNC_SLEEP;
      else if (r < 80) f = FUNC_WAKE;
      else if (r < 91) f = FUNC_WAIT;
      else f = FUNC_FAULT;
      r = $urandom_range(99);
      if (r < 75) target = any_live_pid();
      else if (r < 85) target = id_counter;
      else target = pid_type'($urandom_range(65535));
      vec = vec_type'($urandom_range(31));
      user = 1'($urandom_range(1));
      if (f == FUNC_FAULT) begin
         user = 1'b1;
         while (vec == VEC_DOUBLE_FAULT || vec == VEC_MACHINE_CHECK) begin
            vec = vec_type'($urandom_range(31));
         end
      end
      if (count_live() <= 1) begin
         if ((f == FUNC_EXIT && find_task(target) >= 0) || (f == FUNC_FAULT && running)) begin
            f = FUNC_ADD;
         end
      end
      issue(f, target, vec, user, 1'b0, NO_WORD);
   endtask

   always @(posedge clock) begin : check_words
      rsp_word_type want;
      logic         bad;
      if (!reset && rsp_strobe) begin
         words_checked++;
         if (due_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected word: status %0d pid %0d switched %0d assigned %0d",
                        rsp_status, rsp_current_pid, rsp_switched, rsp_assigned_pid);
            end
         end else begin
            want = due_words.pop_front();
            bad = (rsp_status !== want.status) || (rsp_current_pid !== want.current_pid)
                  || (rsp_switched !== want.switched)
                  || (rsp_assigned_pid !== want.assigned_pid);
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("word %0d mismatch: status %0d/%0d pid %0d/%0d",
                           words_checked, want.status, rsp_status,
                           want.current_pid, rsp_current_pid,
                           " switched %0d/%0d assigned %0d/%0d",
                           want.switched, rsp_switched,
                           want.assigned_pid, rsp_assigned_pid);
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("[round_robin_task_scheduler] ERROR");
      $finish;
   end

   initial begin
      quantum_type quanta [4];
      int          idle_by_phase [4];
      int          kind;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         task_live[s] = 1'b0;
         task_pid[s] = '0;
         task_state[s] = TASK_READY;
         task_wait_on[s] = '0;
      end
      run_slot = '0;
      running = 1'b0;
      tick_total = '0;
      id_counter = pid_type'(1);
      sched_halted = 1'b0;
      quantum_reg = QUANTUM_RESET;
      quanta = '{8'd1, 8'd0, 8'd255, quantum_type'($urandom_range(2, 12))};
      idle_by_phase = '{27, 79, 0, 0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue(directed_rows[i].f, directed_rows[i].target, directed_rows[i].vec,
               directed_rows[i].user, directed_rows[i].typed, directed_rows[i].word);
      end

      for (int ph = 0; ph < 4; ph++) begin
         write_quantum(quanta[ph]);
         sender_idle_pct = idle_by_phase[ph];
         repeat (PHASE_ITEMS) random_command();
      end

      // drive the scheduler into its halted state one way or another
      kind = $urandom_range(4);
      case (kind)
         0: issue(FUNC_FAULT, pid_type'($urandom_range(65535)), vec_type'($urandom_range(31)),
                  1'b0, 1'b0, NO_WORD);
         1: issue(FUNC_FAULT, '0, VEC_DOUBLE_FAULT, 1'b1, 1'b0, NO_WORD);
         2: issue(FUNC_FAULT, '0, VEC_MACHINE_CHECK, 1'b1, 1'b0, NO_WORD);
         3: begin
            for (int g = 0; g < 40 && !sched_halted; g++) begin
               issue(FUNC_EXIT, any_live_pid(), '0, 1'b0, 1'b0, NO_WORD);
            end
         end
         default: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (task_live[s]) begin
                  issue(FUNC_WAKE, task_pid[s], '0, 1'b0, 1'b0, NO_WORD);
               end
            end
            for (int g = 0; g < 40 && !sched_halted; g++) begin
               if (!running) begin
                  issue(FUNC_TICK, '0, '0, 1'b0, 1'b0, NO_WORD);
               end else begin
                  issue(FUNC_FAULT, '0, vec_type'(3), 1'b1, 1'b0, NO_WORD);
               end
            end
         end
      endcase
      if (!sched_halted) begin
         issue(FUNC_FAULT, '0, '0, 1'b0, 1'b0, NO_WORD);
      end
      repeat (8) begin
         issue(func_type'($urandom_range(7)), pid_type'($urandom_range(65535)),
               vec_type'($urandom_range(31)), 1'($urandom_range(1)), 1'b0, NO_WORD);
      end

      while (due_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("ran %0d commands and checked %0d result words over quanta 5, 1, 0, 255 and %0d",
               items_sent, words_checked, quanta[3]);
      $display("halted by path %0d at the end, %0d mismatching words", kind, mismatch_count);
      if (mismatch_count == 0 && due_words.size() == 0) begin
         $display("[round_robin_task_scheduler] OK");
      end else begin
         $display("[round_robin_task_scheduler] ERROR");
      end
      $finish;
   end

endmodule

// ===== round_robin_task_scheduler.f =====
hdl/rrts_pkg.sv
hdl/rrts_slot_table.sv
hdl/rrts_seq.sv
hdl/round_robin_task_scheduler.sv
test/round_robin_task_scheduler_test.sv
